>>> rtl/core/lffp_pkg.sv
`timescale 1ns / 1ps

package lffp_pkg;

  // Strip geometry
  localparam int MAX_LEDS = 64;
  localparam int FRAME_W  = 64;
  localparam int CNT_W    = 7;   // holds 0..MAX_LEDS
  localparam int STEP_W   = 8;
  localparam int SHIFT_W  = 6;   // bit position inside the frame

  localparam logic [CNT_W-1:0] MAX_LEDS_C    = CNT_W'(MAX_LEDS);
  localparam logic [CNT_W-1:0] LED_COUNT_RST = CNT_W'(64);

  // Register map, word index from paddr[3:2]
  localparam logic [1:0] REG_LED_COUNT  = 2'd0;
  localparam logic [1:0] REG_DIRECTION  = 2'd1;
  localparam logic [1:0] REG_ACTIVE_LOW = 2'd2;

  // Fill modes
  typedef enum logic [1:0] {
    DIR_LEFT    = 2'd0,
    DIR_RIGHT   = 2'd1,
    DIR_CLOSE   = 2'd2,
    DIR_DIFFUSE = 2'd3
  } dir_t;

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  // rem is always below p, so the result is too.
  function automatic logic [CNT_W-1:0] div_step(input logic [CNT_W-1:0] rem,
                                                input logic              b,
                                                input logic [CNT_W-1:0] p);
    logic [CNT_W:0] t;
    logic [CNT_W:0] d;
    t = {rem, b};
    d = t - {1'b0, p};
    if (t >= {1'b0, p}) begin
      div_step = d[CNT_W-1:0];
    end else begin
      div_step = t[CNT_W-1:0];
    end
  endfunction

  // len ones from bit 0 upward; len of MAX_LEDS or more fills the frame
  function automatic logic [FRAME_W-1:0] low_mask(input logic [CNT_W-1:0] len);
    logic [FRAME_W-1:0] m;
    for (int i = 0; i < FRAME_W; i++) begin
      m[i] = (CNT_W'(i) < len);
    end
    low_mask = m;
  endfunction

endpackage

>>> rtl/core/led_flowing_fill_pattern.sv
`timescale 1ns / 1ps

// LED strip frame generator. Each request carries a step number and returns one
// 64-bit frame (bit n drives LED n) for the configured fill mode, LED count and
// polarity. A new request is taken every cycle unless a stalled output holds it
// off; a request passes the request register, two divider stages and the output
// register in turn. The step-to-fill count is a modulo by the mode's period,
// done as an 8-step restoring divider split over two pipeline stages, followed by
// the mask-building logic in front of the output register. Each stage holds its
// request independently, so bubbles close up behind a stalled output. Registers
// sit at byte addresses 0x0 (led_count), 0x4 (direction) and 0x8 (active_low);
// write them only while no request is in flight.
module led_flowing_fill_pattern (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lffp_pkg::STEP_W-1:0]    in_step,
  // frame channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lffp_pkg::FRAME_W-1:0]   out_frame,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int CW = lffp_pkg::CNT_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CW-1:0]        led_count_r;
  lffp_pkg::dir_t       direction_r;
  logic                 active_low_r;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r  <= lffp_pkg::LED_COUNT_RST;
      direction_r  <= lffp_pkg::DIR_LEFT;
      active_low_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        lffp_pkg::REG_LED_COUNT:  led_count_r  <= pwdata[CW-1:0];
        lffp_pkg::REG_DIRECTION:  direction_r  <= lffp_pkg::dir_t'(pwdata[1:0]);
        lffp_pkg::REG_ACTIVE_LOW: active_low_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[3:2])
      lffp_pkg::REG_LED_COUNT:  prdata = 32'(led_count_r);
      lffp_pkg::REG_DIRECTION:  prdata = 32'(direction_r);
      lffp_pkg::REG_ACTIVE_LOW: prdata = 32'(active_low_r);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Derived geometry (the user keeps it static while requests are in flight; the block does not enforce it)
  // ---------------------------------------------------------------------------
  logic [CW-1:0] n_sat;
  logic [CW-1:0] n_inc;
  logic [CW-1:0] half;
  logic [CW-1:0] period;
  logic          n_zero;

  always_comb begin
    n_sat  = (led_count_r > lffp_pkg::MAX_LEDS_C) ? lffp_pkg::MAX_LEDS_C : led_count_r;
    n_inc  = n_sat + CW'(1);
    half   = n_inc >> 1;
    n_zero = (n_sat == '0);
    if (n_zero) begin
      period = CW'(1);   // keeps the divider sane; frame is background anyway
    end else if (direction_r == lffp_pkg::DIR_LEFT || direction_r == lffp_pkg::DIR_RIGHT) begin
      period = n_sat;
    end else begin
      period = half;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: each stage moves when empty or when the next one moves
  // ---------------------------------------------------------------------------
  logic s0_valid_r, s1_valid_r, s2_valid_r, out_valid_r;
  logic en0, en1, en2, en3;

  assign en3      = !out_valid_r || !out_stall;
  assign en2      = !s2_valid_r  || en3;
  assign en1      = !s1_valid_r  || en2;
  assign en0      = !s0_valid_r  || en1;
  assign in_stall = !en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en0) s0_valid_r  <= in_valid;
      if (en1) s1_valid_r  <= s0_valid_r;
      if (en2) s2_valid_r  <= s1_valid_r;
      if (en3) out_valid_r <= s2_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: request register
  // ---------------------------------------------------------------------------
  logic [lffp_pkg::STEP_W-1:0] s0_step_r;

  always_ff @(posedge clk) begin
    if (en0) s0_step_r <= in_step;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: upper four divider steps on step - 1
  // ---------------------------------------------------------------------------
  logic [lffp_pkg::STEP_W-1:0] s0_dvd;
  logic [CW-1:0]               s1_rem_nxt;
  logic [CW-1:0]               s1_rem_r;
  logic [3:0]                  s1_dlo_r;
  logic                        s1_one_r;
  logic                        s1_zero_r;

  assign s0_dvd = s0_step_r - lffp_pkg::STEP_W'(1);

  always_comb begin
    s1_rem_nxt = '0;
    for (int i = 7; i >= 4; i--) begin
      s1_rem_nxt = lffp_pkg::div_step(s1_rem_nxt, s0_dvd[i], period);
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_rem_r  <= s1_rem_nxt;
      s1_dlo_r  <= s0_dvd[3:0];
      s1_one_r  <= (s0_step_r == lffp_pkg::STEP_W'(1));
      s1_zero_r <= (s0_step_r == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: lower four divider steps, fill count c = rem + 1
  // ---------------------------------------------------------------------------
  logic [CW-1:0] s2_rem;
  logic [CW-1:0] s2_c_nxt;
  logic [CW-1:0] s2_c_r;
  logic          s2_one_r;
  logic          s2_zero_r;

  always_comb begin
    s2_rem = s1_rem_r;
    for (int i = 3; i >= 0; i--) begin
      s2_rem = lffp_pkg::div_step(s2_rem, s1_dlo_r[i], period);
    end
    s2_c_nxt = s2_rem + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_c_r    <= s2_c_nxt;
      s2_one_r  <= s1_one_r;
      s2_zero_r <= s1_zero_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: lit mask by mode, polarity, output register
  // ---------------------------------------------------------------------------
  logic [lffp_pkg::FRAME_W-1:0] lm;
  logic [lffp_pkg::FRAME_W-1:0] lit;
  logic [lffp_pkg::FRAME_W-1:0] out_frame_nxt;
  logic [lffp_pkg::FRAME_W-1:0] out_frame_r;
  logic [CW-1:0]                top_lo;   // first LED of the top-end run
  logic [CW-1:0]                n_half;   // upper centre LED
  logic [CW-1:0]                dif_lo;   // first LED of the lower diffuse run

  always_comb begin
    lm     = lffp_pkg::low_mask(s2_c_r);
    top_lo = n_sat - s2_c_r;
    n_half = n_sat >> 1;
    dif_lo = n_sat[0] ? (n_half + CW'(1) - s2_c_r) : (n_half - s2_c_r);
    case (direction_r)
      lffp_pkg::DIR_LEFT:    lit = lm << top_lo[lffp_pkg::SHIFT_W-1:0];
      lffp_pkg::DIR_RIGHT:   lit = lm;
      lffp_pkg::DIR_CLOSE:   lit = lm | (lm << top_lo[lffp_pkg::SHIFT_W-1:0]);
      lffp_pkg::DIR_DIFFUSE: lit = (lm << dif_lo[lffp_pkg::SHIFT_W-1:0])
                                 | (lm << n_half[lffp_pkg::SHIFT_W-1:0]);
      default:               lit = '0;
    endcase
    if (s2_zero_r || n_zero) begin
      lit = '0;
    end
    // step one is all zero in either polarity
    if (s2_one_r) begin
      out_frame_nxt = '0;
    end else begin
      out_frame_nxt = active_low_r ? ~lit : lit;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) out_frame_r <= out_frame_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_frame = out_frame_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // input is held off only by a waiting frame at the output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("request stalled without output backpressure");

  // an accepted request occupies the first stage next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s0_valid_r)
    else $error("accepted request lost at stage 0");

  // partial remainder stays below the period
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (s1_rem_r < period))
    else $error("divider partial remainder out of range");

  // fill count lies in 1..period
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (s2_c_r >= CW'(1) && s2_c_r <= period))
    else $error("fill count out of range");

endmodule
